// File: rtl/core/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round-robin quantum scheduler: request and
// result transaction structs, request codes, controller states and commands.
// ----------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

	// field widths of the transaction payloads
	localparam int unsigned ID_W     = 8;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned QUANT_W  = 16;
	localparam int unsigned WCOUNT_W = 5;

	// request codes
	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_PICK    = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_PREEMPT = 2'd3
	} req_kind_t;

	// request transaction
	typedef struct packed {
		req_kind_t           req_type;
		logic [ID_W-1:0]     task_id;
		logic                task_valid;
		logic [TIME_W-1:0]   arrival_time;
		logic                running_in_io;
	} req_t;

	// result transaction
	typedef struct packed {
		logic                picked_valid;
		logic [ID_W-1:0]     picked_id;
		logic                preempt;
		logic [WCOUNT_W-1:0] waiting_count;
		logic                overflow;
	} rsp_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_RESP = 2'd2
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/round_robin_quantum_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Round-robin scheduler with an arrival-ordered ready queue and a time quantum.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (enqueue, pick, tick or preempt check) is taken on
//   req at a rising edge where start is high and busy is low. Busy then stays
//   high while the request executes.
//   Each request gives exactly one result on rsp, marked by done for one
//   cycle; the receiver must take it in that cycle, there is no back-pressure.
//   The controller steps through accept, execute and result; a new request
//   is taken only once busy is low again after the result. The queue insert
//   compares all queue cells at once and shifts them in the execute state.
//   The quantum length is written through cfg_we / cfg_wdata while idle;
//   the user is bound to that, as the block itself leaves it unenforced.
//   Reset: empty queue, no last-run task, quantum left zero, quantum length
//   one. Queue cells are not cleared; only filled cells are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_quantum_scheduler_core #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire rrqs_pkg::req_t               req,
	output logic                              done,
	output rrqs_pkg::rsp_t                    rsp,
	input  wire logic                         cfg_we,
	input  wire logic [rrqs_pkg::QUANT_W-1:0] cfg_wdata
);

	rrqs_pkg::ctrl_cmd_t cmd;

	// sequencer
	rrqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// queue and scheduling state
	rrqs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/core/rrqs_ctrl.sv
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Sequencer of the scheduler: accepts one request transaction, lets the
// datapath execute it, then strobes the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output rrqs_pkg::ctrl_cmd_t     cmd
);

	rrqs_pkg::state_t state_q;
	rrqs_pkg::state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rrqs_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = rrqs_pkg::ST_EXEC;
				end
			end
			rrqs_pkg::ST_EXEC: begin
				state_nx = rrqs_pkg::ST_RESP;
			end
			rrqs_pkg::ST_RESP: begin
				state_nx = rrqs_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rrqs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			rrqs_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			rrqs_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			rrqs_pkg::ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// result strobe follows acceptance after the execute state
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result not strobed two cycles after acceptance");

	// strobe lasts one cycle and frees the block
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("result strobe not followed by idle");

endmodule

`default_nettype wire

// File: rtl/core/rrqs_datapath.sv
// ----------------------------------------------------------------------------
// rrqs_datapath
// Arrival-ordered ready queue held as a row of shift cells, the last-run task
// and quantum registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_datapath #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rrqs_pkg::ctrl_cmd_t          cmd,
	input  wire rrqs_pkg::req_t               req,
	input  wire logic                         cfg_we,
	input  wire logic [rrqs_pkg::QUANT_W-1:0] cfg_wdata,
	output rrqs_pkg::rsp_t                    rsp
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// latched request
	rrqs_pkg::req_t req_q;

	// queue cells
	logic [rrqs_pkg::ID_W-1:0]   ids_q   [QUEUE_DEPTH];
	logic [rrqs_pkg::TIME_W-1:0] times_q [QUEUE_DEPTH];
	logic [rrqs_pkg::ID_W-1:0]   ids_nx  [QUEUE_DEPTH];
	logic [rrqs_pkg::TIME_W-1:0] times_nx[QUEUE_DEPTH];
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_nx;

	// scheduling state
	logic [rrqs_pkg::ID_W-1:0]    lr_id_q, lr_id_nx;
	logic                         lr_valid_q, lr_valid_nx;
	logic [rrqs_pkg::QUANT_W-1:0] quant_left_q, quant_left_nx;
	logic [rrqs_pkg::QUANT_W-1:0] quant_len_q;

	// result
	rrqs_pkg::rsp_t rsp_q;
	rrqs_pkg::rsp_t rsp_nx;

	logic [QUEUE_DEPTH-1:0] le;
	logic                   full;
	logic                   same;
	logic [31:0]            count_wide;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// quantum length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_len_q <= rrqs_pkg::QUANT_W'(1);
		end else if (cfg_we) begin
			quant_len_q <= cfg_wdata;
		end
	end

	// per-cell compare: entry is valid and not later than the new task
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CW'(i) < count_q) && (times_q[i] <= req_q.arrival_time);
		end
	end

	assign full       = (count_q >= CW'(QUEUE_DEPTH));
	assign same       = (req_q.task_valid == lr_valid_q) &&
	                    (!req_q.task_valid || (req_q.task_id == lr_id_q));
	assign count_wide = 32'(count_nx);

	// next state of queue and scheduler
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ids_nx[i]   = ids_q[i];
			times_nx[i] = times_q[i];
		end
		count_nx      = count_q;
		lr_id_nx      = lr_id_q;
		lr_valid_nx   = lr_valid_q;
		quant_left_nx = quant_left_q;
		rsp_nx        = '0;
		case (req_q.req_type)
			rrqs_pkg::REQ_ENQUEUE: begin
				if (full) begin
					rsp_nx.overflow = 1'b1;
				end else begin
					// head cell takes the new task unless it arrived no later
					if (!le[0]) begin
						ids_nx[0]   = req_q.task_id;
						times_nx[0] = req_q.arrival_time;
					end
					// cells past the insert point shift up by one
					for (int i = 1; i < QUEUE_DEPTH; i++) begin
						if (!le[i]) begin
							if (le[i-1]) begin
								ids_nx[i]   = req_q.task_id;
								times_nx[i] = req_q.arrival_time;
							end else begin
								ids_nx[i]   = ids_q[i-1];
								times_nx[i] = times_q[i-1];
							end
						end
					end
					count_nx = count_q + CW'(1);
				end
			end
			rrqs_pkg::REQ_PICK: begin
				if (count_q != '0) begin
					// pop head, cells shift down by one
					for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
						ids_nx[i]   = ids_q[i+1];
						times_nx[i] = times_q[i+1];
					end
					count_nx            = count_q - CW'(1);
					lr_id_nx            = ids_q[0];
					lr_valid_nx         = 1'b1;
					quant_left_nx       = quant_len_q;
					rsp_nx.picked_valid = 1'b1;
					rsp_nx.picked_id    = ids_q[0];
				end
			end
			rrqs_pkg::REQ_TICK: begin
				if (lr_valid_q && !req_q.running_in_io && (quant_left_q != '0)) begin
					quant_left_nx = quant_left_q - rrqs_pkg::QUANT_W'(1);
				end
			end
			rrqs_pkg::REQ_PREEMPT: begin
				if (!same) begin
					// adopt the running task
					lr_valid_nx   = req_q.task_valid;
					lr_id_nx      = req_q.task_valid ? req_q.task_id : '0;
					quant_left_nx = quant_len_q;
				end else if ((quant_left_q == '0) && (count_q != '0)) begin
					lr_valid_nx    = 1'b0;
					lr_id_nx       = '0;
					quant_left_nx  = quant_len_q;
					rsp_nx.preempt = 1'b1;
				end
			end
			default: begin
				rsp_nx = '0;
			end
		endcase
		rsp_nx.waiting_count = count_wide[rrqs_pkg::WCOUNT_W-1:0];
	end

	// queue cells and result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				ids_q[i]   <= ids_nx[i];
				times_q[i] <= times_nx[i];
			end
			rsp_q <= rsp_nx;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			lr_id_q      <= '0;
			lr_valid_q   <= 1'b0;
			quant_left_q <= '0;
		end else if (cmd.exec) begin
			count_q      <= count_nx;
			lr_id_q      <= lr_id_nx;
			lr_valid_q   <= lr_valid_nx;
			quant_left_q <= quant_left_nx;
		end
	end

	assign rsp = rsp_q;

	// fill count never passes the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

endmodule

`default_nettype wire

// File: tb/round_robin_quantum_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_checker
// Watches the request, result and quantum write channels of the scheduler,
// keeps its own copy of the ready queue, last-run task and quantum, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

module round_robin_quantum_scheduler_checker #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         busy,
	input  wire rrqs_pkg::req_t               req,
	input  wire logic                         done,
	input  wire rrqs_pkg::rsp_t               rsp,
	input  wire logic                         cfg_we,
	input  wire logic [rrqs_pkg::QUANT_W-1:0] cfg_wdata,
	output int                                pending,
	output int                                fail_count
);

	// shadow scheduler state
	logic [rrqs_pkg::ID_W-1:0]    ready_ids   [QUEUE_DEPTH];
	logic [rrqs_pkg::TIME_W-1:0]  ready_times [QUEUE_DEPTH];
	int unsigned                  ready_count;
	logic [rrqs_pkg::ID_W-1:0]    cur_id;
	logic                         cur_valid;
	logic [rrqs_pkg::QUANT_W-1:0] slice_left;
	logic [rrqs_pkg::QUANT_W-1:0] slice_len;

	rrqs_pkg::rsp_t due_results [$];
	int             mismatch_count = 0;

	assign fail_count = mismatch_count;

	// one line per mismatch
	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0d ns: mismatch on %s, got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// advance the shadow scheduler by one request transaction
	function automatic rrqs_pkg::rsp_t schedule_step(input rrqs_pkg::req_t r);
		rrqs_pkg::rsp_t res;
		int unsigned    pos;
		int unsigned    k;
		logic           same_task;
		res = '0;
		case (r.req_type)
			rrqs_pkg::REQ_ENQUEUE: begin
				if (ready_count >= QUEUE_DEPTH) begin
					res.overflow = 1'b1;
				end else begin
					// insert behind every entry with equal or earlier arrival
					pos = 0;
					while (pos < ready_count && ready_times[pos] <= r.arrival_time)
						pos++;
					for (k = ready_count; k > pos; k--) begin
						ready_ids[k]   = ready_ids[k-1];
						ready_times[k] = ready_times[k-1];
					end
					ready_ids[pos]   = r.task_id;
					ready_times[pos] = r.arrival_time;
					ready_count++;
				end
			end
			rrqs_pkg::REQ_PICK: begin
				if (ready_count > 0) begin
					res.picked_valid = 1'b1;
					res.picked_id    = ready_ids[0];
					for (k = 1; k < ready_count; k++) begin
						ready_ids[k-1]   = ready_ids[k];
						ready_times[k-1] = ready_times[k];
					end
					ready_count--;
					cur_id     = res.picked_id;
					cur_valid  = 1'b1;
					slice_left = slice_len;
				end
			end
			rrqs_pkg::REQ_TICK: begin
				if (cur_valid && !r.running_in_io && slice_left != 0)
					slice_left--;
			end
			rrqs_pkg::REQ_PREEMPT: begin
				same_task = (r.task_valid == cur_valid) &&
					(!r.task_valid || r.task_id == cur_id);
				if (!same_task) begin
					// adopt the running task without preemption
					cur_valid  = r.task_valid;
					cur_id     = r.task_valid ? r.task_id : '0;
					slice_left = slice_len;
				end else if (slice_left == 0 && ready_count > 0) begin
					cur_valid     = 1'b0;
					cur_id        = '0;
					slice_left    = slice_len;
					res.preempt   = 1'b1;
				end
			end
			default: ;
		endcase
		res.waiting_count = ready_count[rrqs_pkg::WCOUNT_W-1:0];
		return res;
	endfunction

	// compare results, track quantum writes, predict accepted requests
	always @(posedge clk or negedge arst_n) begin : watch
		rrqs_pkg::rsp_t want;
		if (!arst_n) begin
			ready_count = 0;
			cur_id      = '0;
			cur_valid   = 1'b0;
			slice_left  = '0;
			slice_len   = rrqs_pkg::QUANT_W'(1);
			due_results.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = due_results.pop_front();
					if (rsp.picked_valid !== want.picked_valid)
						flag_mismatch("picked_valid", rsp.picked_valid, want.picked_valid);
					if (rsp.picked_id !== want.picked_id)
						flag_mismatch("picked_id", rsp.picked_id, want.picked_id);
					if (rsp.preempt !== want.preempt)
						flag_mismatch("preempt", rsp.preempt, want.preempt);
					if (rsp.waiting_count !== want.waiting_count)
						flag_mismatch("waiting_count", rsp.waiting_count, want.waiting_count);
					if (rsp.overflow !== want.overflow)
						flag_mismatch("overflow", rsp.overflow, want.overflow);
				end
			end
			if (cfg_we)
				slice_len = cfg_wdata;
			if (start && !busy)
				due_results.push_back(schedule_step(req));
			pending <= due_results.size();
		end
	end

endmodule

// File: tb/round_robin_quantum_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core_tb
// Drives the scheduler with a directed sequence (empty pick, full queue,
// equal arrival times, quantum run-out and preemption) and then random
// request transactions under several quantum settings and sender idle rates.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module round_robin_quantum_scheduler_core_tb;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned RANDOM_ITEMS = 1440;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	rrqs_pkg::req_t               req;
	logic                         done;
	rrqs_pkg::rsp_t               rsp;
	logic                         cfg_we;
	logic [rrqs_pkg::QUANT_W-1:0] cfg_wdata;

	int                           pending;
	int                           fail_count;
	int unsigned                  idle_pct;
	int unsigned                  cycle_count = 0;
	logic [rrqs_pkg::ID_W-1:0]    recent_pick = '0;

	round_robin_quantum_scheduler_core #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	round_robin_quantum_scheduler_checker #(
		.QUEUE_DEPTH(DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// remember the last dequeued task so preempt checks often name it
	always @(posedge clk) begin
		if (done && rsp.picked_valid)
			recent_pick <= rsp.picked_id;
	end

	// hand one request transaction over, idling first at the current rate
	task automatic issue(input rrqs_pkg::req_t r);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send(input rrqs_pkg::req_kind_t kind,
		input logic [rrqs_pkg::ID_W-1:0] id, input logic valid,
		input logic [rrqs_pkg::TIME_W-1:0] arrival, input logic io);
		rrqs_pkg::req_t r;
		r.req_type      = kind;
		r.task_id       = id;
		r.task_valid    = valid;
		r.arrival_time  = arrival;
		r.running_in_io = io;
		issue(r);
	endtask

	// stop sending and wait until every result is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_quantum(input logic [rrqs_pkg::QUANT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random request: well-formed mix with clustered arrival times
	function automatic rrqs_pkg::req_t random_request();
		rrqs_pkg::req_t r;
		int unsigned    kind_roll;
		int unsigned    time_roll;
		r.task_id       = rrqs_pkg::ID_W'($urandom_range(255));
		r.task_valid    = 1'($urandom_range(1));
		r.running_in_io = ($urandom_range(99) < 30);
		time_roll = $urandom_range(9);
		if (time_roll < 5)
			r.arrival_time = rrqs_pkg::TIME_W'($urandom_range(15));
		else if (time_roll == 5)
			r.arrival_time = '1;
		else if (time_roll == 6)
			r.arrival_time = '0;
		else
			r.arrival_time = rrqs_pkg::TIME_W'($urandom_range(16'hFFFF));
		kind_roll = $urandom_range(99);
		if (kind_roll < 36) begin
			r.req_type = rrqs_pkg::REQ_ENQUEUE;
		end else if (kind_roll < 60) begin
			r.req_type = rrqs_pkg::REQ_PICK;
		end else if (kind_roll < 82) begin
			r.req_type = rrqs_pkg::REQ_TICK;
		end else begin
			r.req_type = rrqs_pkg::REQ_PREEMPT;
			if ($urandom_range(99) < 60) begin
				r.task_id    = recent_pick;
				r.task_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// quantum per random phase; the last one is drawn at run time
	logic [rrqs_pkg::QUANT_W-1:0] quanta [PHASES] =
		'{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd2, 16'd0};

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		idle_pct   = 38;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, no running task, quantum at its reset value
		send(rrqs_pkg::REQ_PICK, 8'h00, 1'b0, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_PREEMPT, 8'h00, 1'b0, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_TICK, 8'h00, 1'b0, 16'h0000, 1'b0);
		// fill the queue with extreme and equal arrival times
		send(rrqs_pkg::REQ_ENQUEUE, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
		send(rrqs_pkg::REQ_ENQUEUE, 8'h00, 1'b0, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_ENQUEUE, 8'h5A, 1'b1, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_ENQUEUE, 8'hA5, 1'b0, 16'hFFFF, 1'b1);
		for (int i = 0; i < 12; i++)
			send(rrqs_pkg::REQ_ENQUEUE, rrqs_pkg::ID_W'(8'h10 + i), 1'b0,
				rrqs_pkg::TIME_W'(16'h1357 * (12 - i)), 1'b0);
		// full queue drops the task
		send(rrqs_pkg::REQ_ENQUEUE, 8'h77, 1'b1, 16'h0000, 1'b0);
		// head is the earliest arrival, task 0x00
		send(rrqs_pkg::REQ_PICK, 8'h00, 1'b0, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_TICK, 8'h00, 1'b0, 16'h0000, 1'b1);
		send(rrqs_pkg::REQ_TICK, 8'h00, 1'b0, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_TICK, 8'h00, 1'b0, 16'h0000, 1'b0);
		// spent quantum with tasks waiting, then a changed and an absent task
		send(rrqs_pkg::REQ_PREEMPT, 8'h00, 1'b1, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_PREEMPT, 8'h33, 1'b1, 16'h0000, 1'b0);
		send(rrqs_pkg::REQ_PREEMPT, 8'h33, 1'b0, 16'h0000, 1'b0);

		// random phases: sender idle 38 %, then 74 %, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES - 1)
				write_quantum(rrqs_pkg::QUANT_W'($urandom_range(4, 9)));
			else
				write_quantum(quanta[ph]);
			idle_pct = (ph < 2) ? 38 : (ph < 4) ? 74 : 0;
			repeat (RANDOM_ITEMS / PHASES) issue(random_request());
		end
		settle();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/rrqs_pkg.sv
rtl/core/rrqs_ctrl.sv
rtl/core/rrqs_datapath.sv
rtl/core/round_robin_quantum_scheduler_core.sv
tb/round_robin_quantum_scheduler_checker.sv
tb/round_robin_quantum_scheduler_core_tb.sv
